// ===== rtl/core/btct_pkg.sv =====
// ----------------------------------------------------------------------------
// btct_pkg
// Shared constants and types for the bed tilt coordinate transform core.
// ----------------------------------------------------------------------------
package btct_pkg;

   localparam int COORD_BITS_DEF   = 20;
   localparam int NORMAL_FRAC_BITS = 16;
   localparam int NORMAL_W         = 24;
   localparam int PIVOT_W          = 60;
   localparam int UNIT_FRAC        = 28;
   localparam int UNIT_W           = 31;   // Q2.28 plus sign, magnitude <= 2^28 + 1
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 60;

   localparam logic [NORMAL_W-1:0] NORMAL_ONE = NORMAL_W'(1 << NORMAL_FRAC_BITS);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_TILT_ENABLE  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_NORMAL_X     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_NORMAL_Y     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_NORMAL_Z     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_PIVOT        = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_VIRT_PIVOT   = 3'd5;

   // vector slots in the coefficient set
   localparam logic [1:0] VEC_N  = 2'd0;
   localparam logic [1:0] VEC_AX = 2'd1;
   localparam logic [1:0] VEC_AY = 2'd2;

   // near-zero normal: squared length k (raw units) counts as zero when
   // k * 1e14 < 2^(2*frac); only k below 4 is ever tested
   localparam bit NZ_1 = (64'd100000000000000 < (64'd1 << (2 * NORMAL_FRAC_BITS)));
   localparam bit NZ_2 = (64'd200000000000000 < (64'd1 << (2 * NORMAL_FRAC_BITS)));
   localparam bit NZ_3 = (64'd300000000000000 < (64'd1 << (2 * NORMAL_FRAC_BITS)));

   typedef struct packed {
      logic                             ready;
      logic                             degen;
      logic [2:0][2:0][UNIT_W-1:0]      coef;   // [vector][component]
   } unit_set_type;

endpackage

// ===== rtl/core/bed_tilt_coordinate_transform_core.sv =====
// ----------------------------------------------------------------------------
// bed_tilt_coordinate_transform_core
// Tilt compensation of target points: rotation about the virtual pivot onto
// the real pivot using a configured plane normal, or a plain pivot offset.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | contents
//  --------+-----------+--------------------+---------------------------------
//  req_    | in        | tvalid/tready      | target x, y, z
//  rsp_    | out       | tvalid/tready      | out x, y, z, degenerate, saturated
//  csr_    | in        | we (no wait)       | six registers by index
//
//  One transfer per cycle unless rsp_ stalls or unit vectors are rebuilt:
//  input register with pivot subtract, nine 31x21 products, three-term sum
//  with pivot, round and saturate into the output register.
//  A stall on rsp_ freezes all four stages together; while the output stage
//  holds a result that is not taken, req_tready stays low.
//  The unit vectors come from a shared sequential unit (root and divide, one
//  bit a cycle); it runs after reset and after every write to a normal
//  register, with req_tready low meanwhile.
//  Reset is synchronous; registers return to tilt off, normal (0,0,1.0).
//
module bed_tilt_coordinate_transform_core
   import btct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int IN_TW     = ((3 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_TW    = ((3 * COORD_BITS + 2 + 7) / 8) * 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_TW-1:0]      req_tdata,   // target_x, target_y, target_z
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_TW-1:0]     rsp_tdata,   // out_x, out_y, out_z,
                                              // degenerate_axis, saturated
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW  = COORD_BITS;
   localparam int DW  = CW + 1;          // target minus virtual pivot
   localparam int PW  = UNIT_W + DW;     // one product
   localparam int AW  = PW + 3;          // sum of three products and pivot
   localparam int EXW = 64 + 3 * CW;     // pivot word, zero above bit 59

   localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (UNIT_FRAC - 1);
   localparam logic signed [AW-1:0] SAT_HI     = AW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] SAT_LO     = -SAT_HI - AW'(1);
   localparam logic [UNIT_W-1:0]    UNIT_ONE   = UNIT_W'(1) << UNIT_FRAC;

   // ---------------- register file ----------------
   logic                tilt_ff;
   logic [NORMAL_W-1:0] normal_x_ff, normal_y_ff, normal_z_ff;
   logic [PIVOT_W-1:0]  pivot_ff, vpivot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_ff     <= 1'b0;
         normal_x_ff <= '0;
         normal_y_ff <= '0;
         normal_z_ff <= NORMAL_ONE;
         pivot_ff    <= '0;
         vpivot_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_TILT_ENABLE: tilt_ff     <= csr_wdata[0];
            REG_NORMAL_X:    normal_x_ff <= csr_wdata[NORMAL_W-1:0];
            REG_NORMAL_Y:    normal_y_ff <= csr_wdata[NORMAL_W-1:0];
            REG_NORMAL_Z:    normal_z_ff <= csr_wdata[NORMAL_W-1:0];
            REG_PIVOT:       pivot_ff    <= csr_wdata[PIVOT_W-1:0];
            REG_VIRT_PIVOT:  vpivot_ff   <= csr_wdata[PIVOT_W-1:0];
            default: ;
         endcase
      end
   end

   // new normal: rebuild the unit vectors
   logic normal_wr;
   assign normal_wr = csr_we && ((csr_addr == REG_NORMAL_X) || (csr_addr == REG_NORMAL_Y)
                              || (csr_addr == REG_NORMAL_Z));

   unit_set_type units;

   btct_unit_gen u_unit_gen (
      .clock    (clock),
      .reset    (reset),
      .start    (normal_wr),
      .normal_x (normal_x_ff),
      .normal_y (normal_y_ff),
      .normal_z (normal_z_ff),
      .units    (units)
   );

   // pivot fields
   logic [EXW-1:0]        piv_ext, vpiv_ext;
   logic signed [CW-1:0]  piv [3];
   logic signed [CW-1:0]  vpiv [3];

   assign piv_ext  = EXW'(pivot_ff);
   assign vpiv_ext = EXW'(vpivot_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         piv[i]  = $signed(piv_ext[i*CW +: CW]);
         vpiv[i] = $signed(vpiv_ext[i*CW +: CW]);
      end
   end

   // coefficient per (output axis i, delta j); identity when tilt is off
   logic signed [UNIT_W-1:0] coef [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (tilt_ff) begin
            coef[i][0] = $signed(units.coef[VEC_AX][i]);
            coef[i][1] = $signed(units.coef[VEC_AY][i]);
            coef[i][2] = $signed(units.coef[VEC_N][i]);
         end else begin
            for (int j = 0; j < 3; j++) begin
               coef[i][j] = (i == j) ? $signed(UNIT_ONE) : '0;
            end
         end
      end
   end

   // ---------------- pipeline ----------------
   logic advance;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;

   assign advance    = !s4_v_ff || rsp_tready;
   assign req_tready = advance && units.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= req_tvalid && units.ready;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   // stage 1: delta from the virtual pivot
   logic signed [DW-1:0] d_in [3];
   logic signed [DW-1:0] d_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         d_in[j] = DW'($signed(req_tdata[j*CW +: CW])) - DW'(vpiv[j]);
      end
   end

   // stage 2: products
   logic signed [PW-1:0] prod_in [3][3];
   logic signed [PW-1:0] prod_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = PW'(coef[i][j]) * PW'(d_ff[j]);
         end
      end
   end

   // stage 3: sum with scaled pivot
   logic signed [AW-1:0] acc_in [3];
   logic signed [AW-1:0] acc_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = (AW'(piv[i]) <<< UNIT_FRAC) + AW'(prod_ff[i][0])
                   + AW'(prod_ff[i][1]) + AW'(prod_ff[i][2]);
      end
   end

   // stage 4: round half up, saturate
   logic signed [AW-1:0] rnd [3];
   logic [CW-1:0]        res_in [3];
   logic [CW-1:0]        res_ff [3];
   logic                 clip_in, clip_ff;
   logic                 degen_ff;

   always_comb begin
      clip_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rnd[i] = (acc_ff[i] + ROUND_HALF) >>> UNIT_FRAC;
         if (rnd[i] > SAT_HI) begin
            res_in[i] = SAT_HI[CW-1:0];
            clip_in   = 1'b1;
         end else if (rnd[i] < SAT_LO) begin
            res_in[i] = SAT_LO[CW-1:0];
            clip_in   = 1'b1;
         end else begin
            res_in[i] = rnd[i][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff     <= d_in;
         prod_ff  <= prod_in;
         acc_ff   <= acc_in;
         res_ff   <= res_in;
         clip_ff  <= clip_in;
         degen_ff <= tilt_ff && units.degen;
      end
   end

   assign rsp_tvalid = s4_v_ff;
   assign rsp_tdata  = OUT_TW'({clip_ff, degen_ff, res_ff[2], res_ff[1], res_ff[0]});

endmodule

// ===== rtl/core/btct_unit_gen.sv =====
// ----------------------------------------------------------------------------
// btct_unit_gen
// Sequential builder of the unit normal and the two unit axes (Q2.28):
// square-sum, even normalising shift, bit-serial root, restoring divide.
// ----------------------------------------------------------------------------
module btct_unit_gen
   import btct_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NORMAL_W-1:0] normal_x,
   input  logic [NORMAL_W-1:0] normal_y,
   input  logic [NORMAL_W-1:0] normal_z,
   output unit_set_type        units
);

   typedef enum logic [5:0] {
      ST_SQ   = 6'b000001,
      ST_NORM = 6'b000010,
      ST_ROOT = 6'b000100,
      ST_LOAD = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } gen_state_type;

   gen_state_type               state_ff, state_in;
   logic [1:0]                  vsel_ff, vsel_in;
   logic [1:0]                  comp_ff, comp_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [4:0]                  shift_ff, shift_in;
   logic [63:0]                 sum_ff, sum_in;
   logic [63:0]                 rad_ff, rad_in;
   logic [63:0]                 res_ff, res_in;
   logic [63:0]                 rem_ff, rem_in;
   logic [29:0]                 quo_ff, quo_in;
   logic                        nzero_ff, nzero_in;
   logic                        degen_ff, degen_in;
   logic [2:0][2:0][UNIT_W-1:0] coef_ff, coef_in;

   logic signed [NORMAL_W:0] ne [3];
   logic signed [NORMAL_W:0] cval;
   logic [NORMAL_W-1:0]      mag;
   logic                     neg;
   logic [47:0]              sq;
   logic [63:0]              sum_sq;
   logic                     near;
   logic [63:0]              bitv, trial_root, trial_div;
   logic [29:0]              quo_next;
   logic                     flip;

   // effective normal: near-zero replaced, flipped to point up
   assign flip = normal_z[NORMAL_W-1];

   always_comb begin
      ne[0] = (NORMAL_W+1)'($signed(normal_x));
      ne[1] = (NORMAL_W+1)'($signed(normal_y));
      ne[2] = (NORMAL_W+1)'($signed(normal_z));
      if (flip) begin
         ne[0] = -ne[0];
         ne[1] = -ne[1];
         ne[2] = -ne[2];
      end
      if (nzero_ff) begin
         ne[0] = '0;
         ne[1] = '0;
         ne[2] = (NORMAL_W+1)'(1);
      end
   end

   // component of the current vector
   always_comb begin
      cval = '0;
      case (vsel_ff)
         VEC_N: begin
            case (comp_ff)
               2'd0:    cval = ne[0];
               2'd1:    cval = ne[1];
               2'd2:    cval = ne[2];
               default: cval = '0;
            endcase
         end
         VEC_AX: begin
            case (comp_ff)
               2'd0:    cval = ne[2];
               2'd2:    cval = -ne[0];
               default: cval = '0;
            endcase
         end
         VEC_AY: begin
            case (comp_ff)
               2'd1:    cval = ne[2];
               2'd2:    cval = -ne[1];
               default: cval = '0;
            endcase
         end
         default: cval = '0;
      endcase
   end

   assign neg    = cval[NORMAL_W];
   assign mag    = neg ? NORMAL_W'(-cval) : NORMAL_W'(cval);
   assign sq     = mag * mag;
   assign sum_sq = sum_ff + 64'(sq);
   assign near   = (sum_sq == 64'd0) || ((sum_sq == 64'd1) && NZ_1)
                || ((sum_sq == 64'd2) && NZ_2) || ((sum_sq == 64'd3) && NZ_3);

   assign bitv       = 64'd1 << {cnt_ff, 1'b0};
   assign trial_root = res_ff + bitv;
   assign trial_div  = res_ff << cnt_ff;
   assign quo_next   = (rem_ff >= trial_div) ? (quo_ff | (30'd1 << cnt_ff)) : quo_ff;

   always_comb begin
      logic             next_vec;
      logic [UNIT_W-1:0] q;
      next_vec = 1'b0;
      q        = UNIT_W'(quo_next);
      state_in = state_ff;
      vsel_in  = vsel_ff;
      comp_in  = comp_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      sum_in   = sum_ff;
      rad_in   = rad_ff;
      res_in   = res_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      nzero_in = nzero_ff;
      degen_in = degen_ff;
      coef_in  = coef_ff;

      unique case (state_ff)
         ST_SQ: begin
            sum_in = sum_sq;
            if (comp_ff == 2'd2) begin
               comp_in  = '0;
               shift_in = '0;
               if ((vsel_ff == VEC_N) && near) begin
                  nzero_in = 1'b1;
                  sum_in   = 64'd1;
                  state_in = ST_NORM;
               end else if (sum_sq == 64'd0) begin
                  coef_in[vsel_ff] = '0;
                  degen_in         = 1'b1;
                  next_vec         = 1'b1;
               end else begin
                  state_in = ST_NORM;
               end
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_NORM: begin
            if (sum_ff[63:60] == 4'd0) begin
               sum_in   = sum_ff << 2;
               shift_in = shift_ff + 5'd1;
            end else begin
               rad_in   = sum_ff;
               res_in   = '0;
               cnt_in   = 5'd30;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rad_ff >= trial_root) begin
               rad_in = rad_ff - trial_root;
               res_in = (res_ff >> 1) + bitv;
            end else begin
               res_in = res_ff >> 1;
            end
            if (cnt_ff == 5'd0) begin
               comp_in  = '0;
               state_in = ST_LOAD;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_LOAD: begin
            rem_in   = (64'(mag) << (6'(shift_ff) + 6'(UNIT_FRAC))) + (res_ff >> 1);
            quo_in   = '0;
            cnt_in   = 5'd29;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= trial_div) begin
               rem_in = rem_ff - trial_div;
            end
            quo_in = quo_next;
            if (cnt_ff == 5'd0) begin
               coef_in[vsel_ff][comp_ff] = neg ? -q : q;
               if (comp_ff == 2'd2) begin
                  next_vec = 1'b1;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_DONE: begin
         end
         default: state_in = ST_SQ;
      endcase

      if (next_vec) begin
         if (vsel_ff == VEC_AY) begin
            state_in = ST_DONE;
         end else begin
            vsel_in  = vsel_ff + 2'd1;
            comp_in  = '0;
            sum_in   = '0;
            state_in = ST_SQ;
         end
      end

      if (start) begin
         state_in = ST_SQ;
         vsel_in  = VEC_N;
         comp_in  = '0;
         sum_in   = '0;
         nzero_in = 1'b0;
         degen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SQ;
         vsel_ff  <= VEC_N;
         comp_ff  <= '0;
         cnt_ff   <= '0;
         shift_ff <= '0;
         sum_ff   <= '0;
         nzero_ff <= 1'b0;
         degen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vsel_ff  <= vsel_in;
         comp_ff  <= comp_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         sum_ff   <= sum_in;
         nzero_ff <= nzero_in;
         degen_ff <= degen_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      res_ff  <= res_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      coef_ff <= coef_in;
   end

   assign units.ready = (state_ff == ST_DONE);
   assign units.degen = degen_ff;
   assign units.coef  = coef_ff;

endmodule

// ===== test/btct_tilt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btct_tilt_checker
// Watches the register port and both streams of the tilt transform core,
// predicts each compensated point and compares it with the returned transfer.
// ----------------------------------------------------------------------------
module btct_tilt_checker
   import btct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [63:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [63:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending,
   output int                    points_checked
);

   typedef longint vec3_type [3];

   // packed from the top bit down: saturated, degenerate, z, y, x
   typedef struct packed {
      logic        sat;
      logic        degen;
      logic [19:0] z;
      logic [19:0] y;
      logic [19:0] x;
   } point_type;

   point_type     point_queue[$];

   logic          tilt_on;
   logic [23:0]   nrm_x, nrm_y, nrm_z;
   logic [59:0]   pivot_r, pivot_v;

   function automatic longint sx20(input logic [19:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // scale to Q2.28 unit length; 0 when the vector has no length
   function automatic bit make_unit(input vec3_type c, output vec3_type u);
      longint unsigned mag[3];
      longint unsigned s, len, q;
      int              h;
      s = 0;
      h = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (c[i] < 0) ? -c[i] : c[i];
         s      = s + mag[i] * mag[i];
      end
      if (s == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
         return 1'b0;
      end
      while ((s >> 60) == 0) begin
         s = s << 2;
         h++;
      end
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q    = ((mag[i] << (h + UNIT_FRAC)) + (len >> 1)) / len;
         u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic point_type compensate(input logic [63:0] data);
      vec3_type        t, r, v, res, nr, n, ax, ay, cx, cy;
      longint unsigned len2, m;
      longint          acc, d[3], hi, lo;
      point_type       p;
      hi    = (64'sd1 <<< 19) - 1;
      lo    = -hi - 1;
      p     = '0;
      for (int i = 0; i < 3; i++) begin
         t[i] = sx20(data[20*i +: 20]);
         r[i] = sx20(pivot_r[20*i +: 20]);
         v[i] = sx20(pivot_v[20*i +: 20]);
      end
      if (!tilt_on) begin
         for (int i = 0; i < 3; i++) res[i] = t[i] + r[i] - v[i];
      end else begin
         nr[0] = longint'($signed(nrm_x));
         nr[1] = longint'($signed(nrm_y));
         nr[2] = longint'($signed(nrm_z));
         len2  = 0;
         for (int i = 0; i < 3; i++) begin
            m    = (nr[i] < 0) ? -nr[i] : nr[i];
            len2 = len2 + m * m;
         end
         // near-zero normal falls back to straight up; else point it upward
         if (len2 < 4 && len2 * 64'd100000000000000 < (64'd1 << (2 * NORMAL_FRAC_BITS)))
         begin
            nr[0] = 0;
            nr[1] = 0;
            nr[2] = 1;
         end else if (nr[2] < 0) begin
            for (int i = 0; i < 3; i++) nr[i] = -nr[i];
         end
         void'(make_unit(nr, n));
         cx[0] = nr[2]; cx[1] = 0;     cx[2] = -nr[0];
         cy[0] = 0;     cy[1] = nr[2]; cy[2] = -nr[1];
         if (!make_unit(cx, ax)) p.degen = 1'b1;
         if (!make_unit(cy, ay)) p.degen = 1'b1;
         for (int i = 0; i < 3; i++) d[i] = t[i] - v[i];
         for (int i = 0; i < 3; i++) begin
            acc    = r[i] * (64'sd1 <<< UNIT_FRAC);
            acc    = acc + ax[i] * d[0] + ay[i] * d[1] + n[i] * d[2];
            res[i] = (acc + (64'sd1 <<< (UNIT_FRAC - 1))) >>> UNIT_FRAC;
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (res[i] > hi) begin res[i] = hi; p.sat = 1'b1; end
         if (res[i] < lo) begin res[i] = lo; p.sat = 1'b1; end
      end
      p.x = res[0][19:0];
      p.y = res[1][19:0];
      p.z = res[2][19:0];
      return p;
   endfunction

   assign pending = point_queue.size();

   always @(posedge clock) begin
      point_type exp_p, got_p;
      if (reset) begin
         tilt_on = 1'b0;
         nrm_x   = '0;
         nrm_y   = '0;
         nrm_z   = NORMAL_ONE;
         pivot_r = '0;
         pivot_v = '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_TILT_ENABLE: tilt_on = csr_wdata[0];
               REG_NORMAL_X:    nrm_x   = csr_wdata[23:0];
               REG_NORMAL_Y:    nrm_y   = csr_wdata[23:0];
               REG_NORMAL_Z:    nrm_z   = csr_wdata[23:0];
               REG_PIVOT:       pivot_r = csr_wdata[59:0];
               REG_VIRT_PIVOT:  pivot_v = csr_wdata[59:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) point_queue.push_back(compensate(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got_p = rsp_tdata[61:0];
            if (point_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result %h", $realtime, got_p);
            end else begin
               exp_p = point_queue.pop_front();
               points_checked++;
               if (got_p.x !== exp_p.x)
                  $display("%0t: out_x exp %h got %h", $realtime, exp_p.x, got_p.x);
               if (got_p.y !== exp_p.y)
                  $display("%0t: out_y exp %h got %h", $realtime, exp_p.y, got_p.y);
               if (got_p.z !== exp_p.z)
                  $display("%0t: out_z exp %h got %h", $realtime, exp_p.z, got_p.z);
               if (got_p.degen !== exp_p.degen)
                  $display("%0t: degenerate exp %b got %b", $realtime, exp_p.degen,
                           got_p.degen);
               if (got_p.sat !== exp_p.sat)
                  $display("%0t: saturated exp %b got %b", $realtime, exp_p.sat, got_p.sat);
               if (got_p !== exp_p) fail_count++;
            end
         end
      end
   end

   initial begin
      fail_count     = 0;
      points_checked = 0;
   end

endmodule

// ===== test/tb_bed_tilt_coordinate_transform_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bed_tilt_coordinate_transform_core
// Stimulus and verdict for the tilt transform core: directed extremes and
// special normals, then random register settings and bursts of points.
// ----------------------------------------------------------------------------
module tb_bed_tilt_coordinate_transform_core;
   import btct_pkg::*;

   localparam int CYCLE_LIMIT = 600000;   // far above the slowest legal run

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid, req_tready;
   logic [63:0]           req_tdata;   // target_x, target_y, target_z
   logic                  rsp_tvalid, rsp_tready;
   logic [63:0]           rsp_tdata;   // out_x, out_y, out_z, degenerate_axis, saturated
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count, pending, points_checked;
   int cycles, points_sent, settings_used;
   int burst_left;
   int rx_count;

   bed_tilt_coordinate_transform_core dut (.*);

   btct_tilt_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // timeout guard
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver stall pattern: four modes in turn, chosen by rx_count[9:8]
   initial begin
      rsp_tready = 1'b0;
      rx_count   = 0;
      forever begin
         @(negedge clock);
         rx_count++;
         case (rx_count[9:8])
            2'd0: rsp_tready <= 1'b1;                        // no stalls
            2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_tready <= (rx_count[2:0] != 3'd5);
            default: rsp_tready <= (rx_count[4:0] > 5'd19);  // long stalls
         endcase
      end
   end

   task automatic reg_write(input logic [CSR_ADDR_W-1:0] idx, input logic [59:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
   endtask

   // all six registers, then the port goes quiet
   task automatic set_regs(input logic en, input logic [23:0] nx, input logic [23:0] ny,
                           input logic [23:0] nz, input logic [59:0] pv,
                           input logic [59:0] vp);
      reg_write(REG_TILT_ENABLE, {59'd0, en});
      reg_write(REG_NORMAL_X, {36'd0, nx});
      reg_write(REG_NORMAL_Y, {36'd0, ny});
      reg_write(REG_NORMAL_Z, {36'd0, nz});
      reg_write(REG_PIVOT, pv);
      reg_write(REG_VIRT_PIVOT, vp);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // one transfer, with optional idle run in front (burst model)
   task automatic send_point(input logic [59:0] p, input bit bursty);
      int gap;
      if (bursty && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, p};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      points_sent++;
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [19:0] rnd_coord(input bit narrow);
      if (narrow) return 20'($signed($urandom_range(0, 4000)) - 2000);
      return 20'($urandom);
   endfunction

   function automatic logic [23:0] rnd_normal(input int kind);
      case (kind)
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(0, 20000)) - 10000);   // small tilt
         2: return 24'($urandom_range(60000, 70000));
         default: return 24'($urandom_range(0, 2));
      endcase
   endfunction

   logic [19:0] dir_t[4][3];
   logic [19:0] cmax, cmin;
   logic [59:0] pv, vp;
   bit          narrow;
   int          n_items;

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_addr    = '0;
      csr_wdata   = '0;
      points_sent = 0;
      settings_used = 0;
      burst_left  = 0;
      cmax = 20'h7FFFF;
      cmin = 20'h80000;
      dir_t = '{'{20'd0, 20'd0, 20'd0}, '{cmax, cmax, cmax},
                '{cmin, cmin, cmin}, '{cmax, cmin, 20'd1}};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: offset only with extreme pivots, straight-up normal,
      // near-zero normal, a normal lying flat (zero-length axis), a
      // downward normal that must be flipped, and extreme normal values
      for (int c = 0; c < 6; c++) begin
         case (c)
            0: set_regs(1'b0, 24'd0, 24'd0, NORMAL_ONE, {3{20'h7FFFF}}, {3{20'h80000}});
            1: set_regs(1'b1, 24'd0, 24'd0, NORMAL_ONE, 60'd0, 60'd0);
            2: set_regs(1'b1, 24'd0, 24'd0, 24'd0, {3{20'h00100}}, 60'd0);
            3: set_regs(1'b1, NORMAL_ONE, 24'd0, 24'd0, 60'd0, {3{20'hFFF00}});
            4: set_regs(1'b1, 24'd3000, -24'sd2000, -24'sd65536, {3{20'h40000}}, 60'd0);
            default: set_regs(1'b1, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                              {60{1'b1}}, {3{20'h7FFFF}});
         endcase
         for (int i = 0; i < 4; i++)
            send_point({dir_t[i][2], dir_t[i][1], dir_t[i][0]}, 1'b0);
         drain();
      end
      // writes to unused indexes must change nothing
      reg_write(3'd6, {60{1'b1}});
      reg_write(3'd7, {60{1'b1}});
      @(negedge clock);
      csr_we <= 1'b0;
      send_point({20'd5, 20'd6, 20'd7}, 1'b0);
      drain();

      // random phases: mostly plausible beds, sometimes wild settings
      for (int ph = 0; ph < 13; ph++) begin
         narrow = ($urandom_range(0, 2) != 0);
         pv = narrow ? {rnd_coord(1), rnd_coord(1), rnd_coord(1)} : 60'({$urandom, $urandom});
         vp = narrow ? {rnd_coord(1), rnd_coord(1), rnd_coord(1)} : 60'({$urandom, $urandom});
         set_regs(ph != 3, rnd_normal($urandom_range(0, 3)), rnd_normal($urandom_range(0, 3)),
                  (ph % 4 == 1) ? rnd_normal(0) : rnd_normal(2), pv, vp);
         n_items = $urandom_range(100, 125);
         for (int i = 0; i < n_items; i++) begin
            send_point({rnd_coord(narrow), rnd_coord(narrow), rnd_coord(narrow)}, ph % 5 != 2);
            // sender holds off mid-phase until the pipe is empty
            if (ph == 4 && i == 50) drain();
         end
         drain();
      end

      $display("Covered %0d register settings, %0d points sent, %0d results checked.",
               settings_used, points_sent, points_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/btct_pkg.sv
rtl/core/btct_unit_gen.sv
rtl/core/bed_tilt_coordinate_transform_core.sv
test/btct_tilt_checker.sv
test/tb_bed_tilt_coordinate_transform_core.sv
